/* sv/cbez_pkg.sv */
// Shared widths, types and register indexes for the cubic Bezier evaluator.
// No dependencies; imported by cubic_bezier_2d_eval.
package cbez_pkg;

	// Coordinate and parameter formats
	localparam int COORD_W = 16;
	localparam int T_FRAC  = 16;
	localparam int T_W     = T_FRAC + 1;

	// Intermediate widths: t and s are at most 2^T_FRAC
	localparam int S3_W    = T_W + 2;            // 3*s
	localparam int SQ_W    = 2 * T_FRAC + 1;     // s*s, t*t
	localparam int ST3_W   = 2 * T_FRAC;         // 3*s*t
	localparam int W_W     = 3 * T_FRAC + 1;     // Bernstein weight, at most 2^(3F)
	localparam int SPLIT   = W_W / 2;            // low part of a weight
	localparam int HI_W    = W_W - SPLIT;        // high part of a weight
	localparam int PH_W    = HI_W + COORD_W;
	localparam int PL_W    = SPLIT + COORD_W;
	localparam int SUMH_W  = PH_W + 2;
	localparam int SUML_W  = PL_W + 2;
	localparam int TOT_W   = SUMH_W + SPLIT + 1;
	localparam int SCALE   = 3 * T_FRAC;         // binary point of the full sum
	localparam int NTERM   = 4;

	localparam logic [T_W-1:0]     T_ONE = T_W'(1) << T_FRAC;
	localparam logic [COORD_W-1:0] CSIGN = COORD_W'(1) << (COORD_W - 1);
	// one half at the final binary point, expressed in the high partial sum
	localparam logic [SUMH_W-1:0]  RND_H = SUMH_W'(1) << (SCALE - 1 - SPLIT);

	// Configuration register indexes
	localparam int IDX_W = 3;
	localparam logic [IDX_W-1:0] REG_P0_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_P0_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_P1_X = 3'd2;
	localparam logic [IDX_W-1:0] REG_P1_Y = 3'd3;
	localparam logic [IDX_W-1:0] REG_P2_X = 3'd4;
	localparam logic [IDX_W-1:0] REG_P2_Y = 3'd5;
	localparam logic [IDX_W-1:0] REG_P3_X = 3'd6;
	localparam logic [IDX_W-1:0] REG_P3_Y = 3'd7;

	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic [IDX_W-1:0]          cfg_idx_t;
	typedef logic [T_W-1:0]            param_t_t;
	typedef logic signed [COORD_W-1:0] point_t;
	typedef logic [W_W-1:0]            weight_t;

endpackage

/* sv/cubic_bezier_2d_eval.sv */
// Cubic Bezier evaluator for two axes, six-stage multiply/accumulate pipeline.
// done rises together with the new point_x and point_y; one point per cycle.
// busy is always low: a new t may be started in every cycle, results cannot stall.
// Reset clears the control points to zero and empties the pipeline valid bits.
// Depends on cbez_pkg.
module cubic_bezier_2d_eval (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  cbez_pkg::param_t_t param_t,
	input  logic              cfg_we,
	input  cbez_pkg::cfg_idx_t cfg_addr,
	input  cbez_pkg::coord_t  cfg_wdata,
	output logic              done,
	output cbez_pkg::point_t  point_x,
	output cbez_pkg::point_t  point_y
);
	import cbez_pkg::*;

	// control point registers
	coord_t px_q [NTERM];
	coord_t py_q [NTERM];

	// stage 1: clamped t, s = 1 - t, 3*s
	logic             vld_s1;
	logic [T_W-1:0]   t_s1, s_s1;
	logic [S3_W-1:0]  s3_s1;
	// stage 2: products of two
	logic             vld_s2;
	logic [T_W-1:0]   t_s2, s_s2;
	logic [SQ_W-1:0]  ss_s2, tt_s2;
	logic [ST3_W-1:0] st3_s2;
	// stage 3: Bernstein weights
	logic             vld_s3;
	weight_t          w_s3 [NTERM];
	// stage 4: split partial products per axis
	logic             vld_s4;
	logic [PH_W-1:0]  phx_s4 [NTERM];
	logic [PL_W-1:0]  plx_s4 [NTERM];
	logic [PH_W-1:0]  phy_s4 [NTERM];
	logic [PL_W-1:0]  ply_s4 [NTERM];
	// stage 5: partial sums
	logic              vld_s5;
	logic [SUMH_W-1:0] shx_s5, shy_s5;
	logic [SUML_W-1:0] slx_s5, sly_s5;

	assign busy = 1'b0;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NTERM; i++) begin
				px_q[i] <= '0;
				py_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_P0_X: px_q[0] <= cfg_wdata;
				REG_P0_Y: py_q[0] <= cfg_wdata;
				REG_P1_X: px_q[1] <= cfg_wdata;
				REG_P1_Y: py_q[1] <= cfg_wdata;
				REG_P2_X: px_q[2] <= cfg_wdata;
				REG_P2_Y: py_q[2] <= cfg_wdata;
				REG_P3_X: px_q[3] <= cfg_wdata;
				REG_P3_Y: py_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			done   <= vld_s5;
		end
	end

	// stage 1: clamp t to one, form s and 3*s
	logic [T_W-1:0] t_c, s_c;
	always_comb begin
		t_c = (param_t > T_ONE) ? T_ONE : param_t;
		s_c = T_ONE - t_c;
	end

	always_ff @(posedge clk) begin
		t_s1  <= t_c;
		s_s1  <= s_c;
		s3_s1 <= (S3_W'(s_c) << 1) + S3_W'(s_c);
	end

	// stage 2: s*s, t*t, 3*s*t
	logic [2*T_W-1:0]    ss_c, tt_c;
	logic [S3_W+T_W-1:0] st3_c;
	always_comb begin
		ss_c  = (2*T_W)'(s_s1) * (2*T_W)'(s_s1);
		tt_c  = (2*T_W)'(t_s1) * (2*T_W)'(t_s1);
		st3_c = (S3_W+T_W)'(s3_s1) * (S3_W+T_W)'(t_s1);
	end

	always_ff @(posedge clk) begin
		ss_s2  <= ss_c[SQ_W-1:0];
		tt_s2  <= tt_c[SQ_W-1:0];
		st3_s2 <= st3_c[ST3_W-1:0];
		s_s2   <= s_s1;
		t_s2   <= t_s1;
	end

	// stage 3: weights s^3, 3s^2t, 3st^2, t^3
	logic [SQ_W+T_W-1:0] w_c [NTERM];
	always_comb begin
		w_c[0] = (SQ_W+T_W)'(ss_s2) * (SQ_W+T_W)'(s_s2);
		w_c[1] = (SQ_W+T_W)'(st3_s2) * (SQ_W+T_W)'(s_s2);
		w_c[2] = (SQ_W+T_W)'(st3_s2) * (SQ_W+T_W)'(t_s2);
		w_c[3] = (SQ_W+T_W)'(tt_s2) * (SQ_W+T_W)'(t_s2);
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NTERM; i++) begin
			w_s3[i] <= w_c[i][W_W-1:0];
		end
	end

	// stage 4: weight halves times offset-binary coordinates
	coord_t ux [NTERM];
	coord_t uy [NTERM];
	always_comb begin
		for (int i = 0; i < NTERM; i++) begin
			ux[i] = px_q[i] ^ CSIGN;
			uy[i] = py_q[i] ^ CSIGN;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NTERM; i++) begin
			phx_s4[i] <= PH_W'(w_s3[i][W_W-1:SPLIT]) * PH_W'(ux[i]);
			plx_s4[i] <= PL_W'(w_s3[i][SPLIT-1:0]) * PL_W'(ux[i]);
			phy_s4[i] <= PH_W'(w_s3[i][W_W-1:SPLIT]) * PH_W'(uy[i]);
			ply_s4[i] <= PL_W'(w_s3[i][SPLIT-1:0]) * PL_W'(uy[i]);
		end
	end

	// stage 5: sum the four terms; rounding half goes into the high sum
	logic [SUMH_W-1:0] shx_c, shy_c;
	logic [SUML_W-1:0] slx_c, sly_c;
	always_comb begin
		shx_c = RND_H;
		shy_c = RND_H;
		slx_c = '0;
		sly_c = '0;
		for (int i = 0; i < NTERM; i++) begin
			shx_c = shx_c + SUMH_W'(phx_s4[i]);
			shy_c = shy_c + SUMH_W'(phy_s4[i]);
			slx_c = slx_c + SUML_W'(plx_s4[i]);
			sly_c = sly_c + SUML_W'(ply_s4[i]);
		end
	end

	always_ff @(posedge clk) begin
		shx_s5 <= shx_c;
		shy_s5 <= shy_c;
		slx_s5 <= slx_c;
		sly_s5 <= sly_c;
	end

	// stage 6: join halves, take the integer part, remove the bias
	logic [TOT_W-1:0] totx_c, toty_c;
	always_comb begin
		totx_c = (TOT_W'(shx_s5) << SPLIT) + TOT_W'(slx_s5);
		toty_c = (TOT_W'(shy_s5) << SPLIT) + TOT_W'(sly_s5);
	end

	always_ff @(posedge clk) begin
		point_x <= point_t'(totx_c[SCALE +: COORD_W] ^ CSIGN);
		point_y <= point_t'(toty_c[SCALE +: COORD_W] ^ CSIGN);
	end

endmodule
